// File: hw/rtl/cvs_pkg.sv
// Shared constants, register codes and the exp mantissa table for the curve value standardizer.
`default_nettype none
package cvs_pkg;

   localparam int SAMPLE_W    = 32;
   localparam int COEF_W      = 48;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 48;

   // Saturated products are signed with a magnitude of at most 2^60.
   localparam int SAT_W = 62;
   localparam int MAG_W = 61;
   localparam logic [MAG_W-1:0] SAT_LIM = {1'b1, 60'd0};

   localparam logic [31:0] LOG2E_Q30 = 32'd1549082005;
   localparam logic [29:0] LN2_Q30   = 30'd744261118;
   localparam logic [31:0] ONE_Q30   = 32'd1073741824;

   localparam logic [CSR_INDEX_W-1:0] CSR_CURVE_KIND    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BENEFIT_MODE  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_COEF_A        = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_COEF_B        = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_COEF_C        = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_DOMAIN_TOP    = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_DOMAIN_BOTTOM = 3'd6;

   typedef enum logic [1:0] {
      KIND_EXP   = 2'd0,
      KIND_QUAD  = 2'd1,
      KIND_GAUSS = 2'd2,
      KIND_NONE  = 2'd3
   } curve_kind_type;

   // One table entry: 2^(idx/2^bits) in Q2.30 from a truncated 14-term series.
   function automatic logic [31:0] exp_entry(input int unsigned idx, input int unsigned bits);
      logic [63:0] x;
      logic [63:0] term;
      logic [63:0] sum;
      x    = (64'(idx) * 64'(LN2_Q30)) >> bits;
      term = 64'(ONE_Q30);
      sum  = term;
      term = ((term * x) >> 30) / 64'd1;  sum = sum + term;
      term = ((term * x) >> 30) / 64'd2;  sum = sum + term;
      term = ((term * x) >> 30) / 64'd3;  sum = sum + term;
      term = ((term * x) >> 30) / 64'd4;  sum = sum + term;
      term = ((term * x) >> 30) / 64'd5;  sum = sum + term;
      term = ((term * x) >> 30) / 64'd6;  sum = sum + term;
      term = ((term * x) >> 30) / 64'd7;  sum = sum + term;
      term = ((term * x) >> 30) / 64'd8;  sum = sum + term;
      term = ((term * x) >> 30) / 64'd9;  sum = sum + term;
      term = ((term * x) >> 30) / 64'd10; sum = sum + term;
      term = ((term * x) >> 30) / 64'd11; sum = sum + term;
      term = ((term * x) >> 30) / 64'd12; sum = sum + term;
      term = ((term * x) >> 30) / 64'd13; sum = sum + term;
      return sum[31:0];
   endfunction

endpackage
`default_nettype wire

// File: hw/rtl/cvs_mul_sat.sv
// Five-stage signed multiplier: magnitude product shifted right and saturated to 2^60.
`default_nettype none
module cvs_mul_sat #(
   parameter int WP = 48,
   parameter int WQ = 64,
   parameter int SH = 24
) (
   input  logic                              clock,
   input  logic                              enable,
   input  logic [WP-1:0]                     op_p,
   input  logic [WQ-1:0]                     op_q,
   output logic signed [cvs_pkg::SAT_W-1:0]  res
);
   import cvs_pkg::*;

   localparam int PL = (WP + 1) / 2;
   localparam int PH = WP - PL;
   localparam int QL = (WQ + 1) / 2;
   localparam int QH = WQ - QL;
   localparam int PW = WP + WQ;
   localparam logic [PW-1:0] LIM_W = PW'(SAT_LIM);

   logic [WP-1:0]        mag_p_in, mag_p_ff;
   logic [WQ-1:0]        mag_q_in, mag_q_ff;
   logic [PL+QL-1:0]     ll_in, ll_ff;
   logic [PL+QH-1:0]     lh_in, lh_ff;
   logic [PH+QL-1:0]     hl_in, hl_ff;
   logic [PH+QH-1:0]     hh_in, hh_ff;
   logic [PW-1:0]        prod_in, prod_ff;
   logic [PW-1:0]        shifted;
   logic [MAG_W-1:0]     mag_in, mag_ff;
   logic [SAT_W-1:0]     ext;
   logic [SAT_W-1:0]     res_in, res_ff;
   logic [3:0]           neg_in, neg_ff;

   // Stage 1: magnitudes and result sign.
   always_comb begin
      mag_p_in = op_p[WP-1] ? (~op_p + WP'(1)) : op_p;
      mag_q_in = op_q[WQ-1] ? (~op_q + WQ'(1)) : op_q;
      neg_in[0] = op_p[WP-1] ^ op_q[WQ-1];
      neg_in[1] = neg_ff[0];
      neg_in[2] = neg_ff[1];
      neg_in[3] = neg_ff[2];
   end

   // Stage 2: four half-by-half partial products.
   always_comb begin
      ll_in = {{QL{1'b0}}, mag_p_ff[PL-1:0]} * {{PL{1'b0}}, mag_q_ff[QL-1:0]};
      lh_in = {{QH{1'b0}}, mag_p_ff[PL-1:0]} * {{PL{1'b0}}, mag_q_ff[WQ-1:QL]};
      hl_in = {{QL{1'b0}}, mag_p_ff[WP-1:PL]} * {{PH{1'b0}}, mag_q_ff[QL-1:0]};
      hh_in = {{QH{1'b0}}, mag_p_ff[WP-1:PL]} * {{PH{1'b0}}, mag_q_ff[WQ-1:QL]};
   end

   // Stage 3: full product; stage 4: shift and saturate; stage 5: apply sign.
   // The low half of p times the high half of q weighs 2^QL, and the reverse 2^PL.
   always_comb begin
      prod_in = PW'(ll_ff) + (PW'(lh_ff) << QL) + (PW'(hl_ff) << PL)
              + (PW'(hh_ff) << (PL + QL));
      shifted = prod_ff >> SH;
      mag_in  = (shifted > LIM_W) ? SAT_LIM : shifted[MAG_W-1:0];
      ext     = {1'b0, mag_ff};
      res_in  = neg_ff[3] ? (~ext + SAT_W'(1)) : ext;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         mag_p_ff <= mag_p_in;
         mag_q_ff <= mag_q_in;
         ll_ff    <= ll_in;
         lh_ff    <= lh_in;
         hl_ff    <= hl_in;
         hh_ff    <= hh_in;
         prod_ff  <= prod_in;
         mag_ff   <= mag_in;
         res_ff   <= res_in;
         neg_ff   <= neg_in;
      end
   end

   assign res = res_ff;

endmodule
`default_nettype wire

// File: hw/rtl/cvs_exp.sv
// Six-stage exp unit: base-2 range reduction, table lookup, quadratic correction, scaling.
`default_nettype none
module cvs_exp #(
   parameter int EXP_TABLE_BITS = 8
) (
   input  logic               clock,
   input  logic               enable,
   input  logic signed [29:0] arg_t,
   output logic [63:0]        exp_e
);
   import cvs_pkg::*;

   localparam int TAB_SIZE = 1 << EXP_TABLE_BITS;
   localparam int GW       = 24 - EXP_TABLE_BITS;

   logic [31:0] tab_rom [TAB_SIZE];

   for (genvar gi = 0; gi < TAB_SIZE; gi++) begin : g_tab
      assign tab_rom[gi] = exp_entry(gi, EXP_TABLE_BITS);
   end

   logic [62:0]               uprod;
   logic [30:0]               u_in, u_ff;
   logic [EXP_TABLE_BITS-1:0] idx;
   logic [GW-1:0]             g;
   logic [GW+29:0]            ymul;
   logic [GW+29:0]            ymul_sh;
   logic [29:0]               y_in, y_ff, y3_in, y3_ff;
   logic [31:0]               tab_in, tab_ff, tab3_in, tab3_ff, tab4_in, tab4_ff;
   logic [6:0]                k_in, k_ff, k3_in, k3_ff, k4_in, k4_ff;
   logic [59:0]               yy_in, yy_ff;
   logic [31:0]               poly_in, poly_ff;
   logic [63:0]               mprod;
   logic [33:0]               m_in, m_ff;
   logic [7:0]                s_in, s_ff;
   logic [7:0]                s_neg;
   logic [63:0]               e_in, e_ff;

   always_comb begin
      // u = floor(t * log2(e)), Q.24 in base 2
      uprod   = {{33{arg_t[29]}}, arg_t} * 63'(LOG2E_Q30);
      u_in    = uprod[60:30];
      k_in    = u_ff[30:24];
      idx     = u_ff[23:GW];
      g       = u_ff[GW-1:0];
      ymul    = {30'd0, g} * {{GW{1'b0}}, LN2_Q30};
      ymul_sh = ymul >> 24;
      y_in    = ymul_sh[29:0];
      tab_in  = tab_rom[idx];
      yy_in   = {30'd0, y_ff} * {30'd0, y_ff};
      y3_in   = y_ff;
      tab3_in = tab_ff;
      k3_in   = k_ff;
      poly_in = ONE_Q30 + 32'(y3_ff) + 32'(yy_ff[59:31]);
      tab4_in = tab3_ff;
      k4_in   = k3_ff;
      mprod   = {32'd0, tab4_ff} * {32'd0, poly_ff};
      m_in    = mprod[63:30];
      s_in    = {k4_ff[6], k4_ff} + 8'd2;
      s_neg   = ~s_ff + 8'd1;
      e_in    = s_ff[7] ? (64'(m_ff) >> s_neg[5:0]) : (64'(m_ff) << s_ff[5:0]);
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         u_ff    <= u_in;
         k_ff    <= k_in;
         y_ff    <= y_in;
         tab_ff  <= tab_in;
         yy_ff   <= yy_in;
         y3_ff   <= y3_in;
         tab3_ff <= tab3_in;
         k3_ff   <= k3_in;
         poly_ff <= poly_in;
         tab4_ff <= tab4_in;
         k4_ff   <= k4_in;
         m_ff    <= m_in;
         s_ff    <= s_in;
         e_ff    <= e_in;
      end
   end

   assign exp_e = e_ff;

endmodule
`default_nettype wire

// File: hw/rtl/curve_value_standardizer.sv
// Top level of the curve value standardizer: configuration registers, pipeline control, datapath.
//
// Each word on the req_ channel carries one signed Q16.16 sample; each word on the rsp_
// channel carries the standardized value, clamped to [domain_bottom, domain_top].
// The csr_ channel writes the seven curve registers; csr_ready is always high and an
// index beyond the list is ignored. Registers must be written only while the block
// holds no word in flight.
// The datapath is a 27-stage pipeline: four multipliers of five stages each,
// a six-stage exp unit, and stages for range clamping, summing, mirroring and the
// final domain clamp. A new sample is taken in every cycle while the pipeline is not
// frozen by a stalled receiver, so sustained throughput is one word per cycle while
// the receiver keeps up.
// When the receiver stalls, the output register holds its word; the pipeline keeps
// moving until a valid word reaches the last stage, which lets bubbles close up, and
// then freezes as a whole, so nothing is lost or repeated.
// Synchronous reset clears all valid bits and loads the register reset values
// (exponential benefit curve, zero coefficients, domain [0, 1]).
`default_nettype none
module curve_value_standardizer #(
   parameter int EXP_TABLE_BITS = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [cvs_pkg::SAMPLE_W-1:0]       req_sample_x,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [cvs_pkg::SAMPLE_W-1:0]       rsp_standard_y,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [cvs_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [cvs_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import cvs_pkg::*;

   // Stages 0 to 25 carry valid bits; the output register is stage 26.
   localparam int NUM_STAGES = 26;
   localparam int X_TAPS     = 19;
   localparam logic signed [SAT_W-1:0] ARG_LO = -62'sd402653184;
   localparam logic signed [SAT_W-1:0] ARG_HI = 62'sd335544320;

   // Configuration registers.
   curve_kind_type      kind_in, kind_ff;
   logic                benefit_in, benefit_ff;
   logic [COEF_W-1:0]   coef_a_in, coef_a_ff;
   logic [COEF_W-1:0]   coef_b_in, coef_b_ff;
   logic [COEF_W-1:0]   coef_c_in, coef_c_ff;
   logic [SAMPLE_W-1:0] top_in, top_ff;
   logic [SAMPLE_W-1:0] bottom_in, bottom_ff;

   always_comb begin
      kind_in    = kind_ff;
      benefit_in = benefit_ff;
      coef_a_in  = coef_a_ff;
      coef_b_in  = coef_b_ff;
      coef_c_in  = coef_c_ff;
      top_in     = top_ff;
      bottom_in  = bottom_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_CURVE_KIND:    kind_in    = curve_kind_type'(csr_wdata[1:0]);
            CSR_BENEFIT_MODE:  benefit_in = csr_wdata[0];
            CSR_COEF_A:        coef_a_in  = csr_wdata[COEF_W-1:0];
            CSR_COEF_B:        coef_b_in  = csr_wdata[COEF_W-1:0];
            CSR_COEF_C:        coef_c_in  = csr_wdata[COEF_W-1:0];
            CSR_DOMAIN_TOP:    top_in     = csr_wdata[SAMPLE_W-1:0];
            CSR_DOMAIN_BOTTOM: bottom_in  = csr_wdata[SAMPLE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff    <= KIND_EXP;
         benefit_ff <= 1'b1;
         coef_a_ff  <= '0;
         coef_b_ff  <= '0;
         coef_c_ff  <= '0;
         top_ff     <= 32'd65536;
         bottom_ff  <= '0;
      end else begin
         kind_ff    <= kind_in;
         benefit_ff <= benefit_in;
         coef_a_ff  <= coef_a_in;
         coef_b_ff  <= coef_b_in;
         coef_c_ff  <= coef_c_in;
         top_ff     <= top_in;
         bottom_ff  <= bottom_in;
      end
   end

   assign csr_ready = 1'b1;

   // Pipeline control. The whole pipe advances together unless a valid word sits in
   // the last stage while the output register is full and not being taken.
   logic                  adv;
   logic                  out_load;
   logic [NUM_STAGES-1:0] vld_in, vld_ff;
   logic                  rsp_valid_in, rsp_valid_ff;

   assign out_load = !rsp_valid_ff || rsp_ready;
   assign adv      = out_load || !vld_ff[NUM_STAGES-1];
   assign req_ready = adv;

   always_comb begin
      vld_in = {vld_ff[NUM_STAGES-2:0], req_valid};
      rsp_valid_in = out_load ? vld_ff[NUM_STAGES-1] : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (adv) begin
            vld_ff <= vld_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Sample delay line: tap i holds the sample of stage i.
   logic [SAMPLE_W-1:0] x_in [X_TAPS];
   logic [SAMPLE_W-1:0] x_ff [X_TAPS];

   always_comb begin
      x_in[0] = req_sample_x;
      for (int i = 1; i < X_TAPS; i++) begin
         x_in[i] = x_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         x_ff <= x_in;
      end
   end

   // Stage 1: gaussian offset d = x - c in Q.24.
   logic [48:0] d_in, d_ff;
   assign d_in = {{9{x_ff[0][31]}}, x_ff[0], 8'd0} - {coef_c_ff[47], coef_c_ff};

   always_ff @(posedge clock) begin
      if (adv) begin
         d_ff <= d_in;
      end
   end

   // Square of the offset, stages 2 to 6.
   logic signed [SAT_W-1:0] sq_res;
   cvs_mul_sat #(.WP(49), .WQ(49), .SH(24)) u_mul_sq (
      .clock  (clock),
      .enable (adv),
      .op_p   (d_ff),
      .op_q   (d_ff),
      .res    (sq_res)
   );

   // Exp argument, stages 7 to 11: b*d^2 for the gaussian, c*x for the exponential.
   // c*x with a shift of 16 equals c*(x*256) with a shift of 24.
   logic [COEF_W-1:0]       arg_p;
   logic [SAT_W-1:0]        arg_q;
   logic signed [SAT_W-1:0] arg_res;

   always_comb begin
      if (kind_ff == KIND_GAUSS) begin
         arg_p = coef_b_ff;
         arg_q = sq_res;
      end else begin
         arg_p = coef_c_ff;
         arg_q = {{22{x_ff[6][31]}}, x_ff[6], 8'd0};
      end
   end

   cvs_mul_sat #(.WP(COEF_W), .WQ(SAT_W), .SH(24)) u_mul_arg (
      .clock  (clock),
      .enable (adv),
      .op_p   (arg_p),
      .op_q   (arg_q),
      .res    (arg_res)
   );

   // Stage 12: clamp the argument to [-24, 20].
   logic signed [29:0] t_in, t_ff;

   always_comb begin
      if (arg_res < ARG_LO) begin
         t_in = ARG_LO[29:0];
      end else if (arg_res > ARG_HI) begin
         t_in = ARG_HI[29:0];
      end else begin
         t_in = arg_res[29:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         t_ff <= t_in;
      end
   end

   // Stages 13 to 18: exponential.
   logic [63:0] exp_e;
   cvs_exp #(.EXP_TABLE_BITS(EXP_TABLE_BITS)) u_exp (
      .clock  (clock),
      .enable (adv),
      .arg_t  (t_ff),
      .exp_e  (exp_e)
   );

   // Stage 18 also forms x*x for the quadratic.
   logic [63:0] xx_in, xx_ff;
   assign xx_in = {{32{x_ff[17][31]}}, x_ff[17]} * {{32{x_ff[17][31]}}, x_ff[17]};

   always_ff @(posedge clock) begin
      if (adv) begin
         xx_ff <= xx_in;
      end
   end

   // Stages 19 to 23: the scaling product and, for the quadratic, the linear term.
   logic [COEF_W-1:0]       main_p;
   logic [63:0]             main_q;
   logic signed [SAT_W-1:0] main_res;
   logic signed [SAT_W-1:0] lin_res;

   always_comb begin
      main_p = (kind_ff == KIND_EXP) ? coef_b_ff : coef_a_ff;
      main_q = (kind_ff == KIND_QUAD) ? xx_ff : exp_e;
   end

   cvs_mul_sat #(.WP(COEF_W), .WQ(64), .SH(40)) u_mul_main (
      .clock  (clock),
      .enable (adv),
      .op_p   (main_p),
      .op_q   (main_q),
      .res    (main_res)
   );

   cvs_mul_sat #(.WP(COEF_W), .WQ(SAMPLE_W), .SH(24)) u_mul_lin (
      .clock  (clock),
      .enable (adv),
      .op_p   (coef_b_ff),
      .op_q   (x_ff[18]),
      .res    (lin_res)
   );

   // Stage 24: curve value; stage 25: cost mirror; stage 26: domain clamp.
   logic signed [63:0] main_w, lin_w, a_q16, c_q16, top_w, bottom_w;
   logic signed [63:0] sum_in, sum_ff;
   logic signed [63:0] mir_in, mir_ff;
   logic [SAMPLE_W-1:0] y_in, y_ff;

   always_comb begin
      main_w   = {{2{main_res[SAT_W-1]}}, main_res};
      lin_w    = {{2{lin_res[SAT_W-1]}}, lin_res};
      a_q16    = {{24{coef_a_ff[47]}}, coef_a_ff[47:8]};
      c_q16    = {{24{coef_c_ff[47]}}, coef_c_ff[47:8]};
      top_w    = {{32{top_ff[31]}}, top_ff};
      bottom_w = {{32{bottom_ff[31]}}, bottom_ff};
      case (kind_ff)
         KIND_EXP:   sum_in = a_q16 + main_w;
         KIND_QUAD:  sum_in = main_w + lin_w + c_q16;
         KIND_GAUSS: sum_in = main_w;
         default:    sum_in = bottom_w;
      endcase
      if (!benefit_ff && (kind_ff == KIND_EXP || kind_ff == KIND_GAUSS)) begin
         mir_in = top_w - sum_ff;
      end else begin
         mir_in = sum_ff;
      end
      // When the bounds are crossed, values below bottom give bottom and all others top.
      if (mir_ff < bottom_w) begin
         y_in = bottom_ff;
      end else if (mir_ff > top_w) begin
         y_in = top_ff;
      end else begin
         y_in = mir_ff[SAMPLE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sum_ff <= sum_in;
         mir_ff <= mir_in;
      end
      if (out_load) begin
         y_ff <= y_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_standard_y = y_ff;

endmodule
`default_nettype wire

// File: verif/curve_value_standardizer_tb.sv
// Self-checking testbench for the curve value standardizer: curve predictor, random traffic.
`default_nettype none
module curve_value_standardizer_tb;
   import cvs_pkg::*;

   // The table size must match the block's default parameter.
   localparam int TABLE_BITS = 8;
   localparam int TABLE_LEN  = 1 << TABLE_BITS;
   // Exp argument limits in Q8.24: -24.0 and +20.0.
   localparam longint ARG_LO = -64'sd402653184;
   localparam longint ARG_HI = 64'sd335544320;
   // Index 7 lies past the register list, so a write to it must change nothing.
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 3'd7;
   // Allow a margin beyond the pipeline depth before moving on.
   localparam int SETTLE_CYCLES = 40;

   // The scoreboard keeps its own copy of the registers and predicts every result
   // word from it. Expected words wait in a queue until the block delivers them.
   class curve_scoreboard;
      curve_kind_type     kind;
      bit                 benefit;
      logic signed [47:0] coef_a, coef_b, coef_c;
      logic signed [31:0] top, bottom;
      logic [63:0]        pow2_table[TABLE_LEN];
      logic [31:0]        expected_y[$];
      int                 failures;

      function new();
         logic [63:0] arg, term, sum;
         kind = KIND_EXP; benefit = 1'b1;
         coef_a = '0; coef_b = '0; coef_c = '0;
         top = 32'sd65536; bottom = '0;
         failures = 0;
         // Each entry is 2^(i/2^bits) in Q2.30 from a truncated series.
         for (int i = 0; i < TABLE_LEN; i++) begin
            arg  = (64'(i) * 64'(LN2_Q30)) >> TABLE_BITS;
            term = 64'(ONE_Q30);
            sum  = term;
            for (int n = 1; n <= 13; n++) begin
               term = ((term * arg) >> 30) / 64'(n);
               sum  = sum + term;
            end
            pow2_table[i] = sum;
         end
      endfunction

      function void set_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_CURVE_KIND:    kind    = curve_kind_type'(data[1:0]);
            CSR_BENEFIT_MODE:  benefit = data[0];
            CSR_COEF_A:        coef_a  = data[47:0];
            CSR_COEF_B:        coef_b  = data[47:0];
            CSR_COEF_C:        coef_c  = data[47:0];
            CSR_DOMAIN_TOP:    top     = data[31:0];
            CSR_DOMAIN_BOTTOM: bottom  = data[31:0];
            default: ;
         endcase
      endfunction

      // Exact product of magnitudes, shifted down, saturated to 2^60, sign restored.
      function longint scaled_product(longint p, longint q, int sh);
         logic [63:0]  up, uq, mag;
         logic [127:0] prod;
         bit           neg;
         neg  = (p < 0) != (q < 0);
         up   = (p < 0) ? 64'(-p) : 64'(p);
         uq   = (q < 0) ? 64'(-q) : 64'(q);
         prod = ({64'd0, up} * {64'd0, uq}) >> sh;
         mag  = (prod > 128'(SAT_LIM)) ? 64'(SAT_LIM) : prod[63:0];
         return neg ? -longint'(mag) : longint'(mag);
      endfunction

      function longint limit_arg(longint t);
         if (t < ARG_LO) return ARG_LO;
         if (t > ARG_HI) return ARG_HI;
         return t;
      endfunction

      // exp(t) for t in Q8.24, returned in Q.32, by base-2 range reduction.
      function logic [63:0] exp_q32(longint t);
         longint      u, k, s;
         logic [63:0] f, idx, g, y, poly, m;
         u    = (t * longint'(LOG2E_Q30)) >>> 30;
         k    = u >>> 24;
         f    = 64'(u - k * 64'sd16777216);
         idx  = (f >> (24 - TABLE_BITS)) & 64'(TABLE_LEN - 1);
         g    = f & ((64'd1 << (24 - TABLE_BITS)) - 64'd1);
         y    = (g * 64'(LN2_Q30)) >> 24;
         poly = 64'(ONE_Q30) + y + ((y * y) >> 31);
         m    = (pow2_table[idx] * poly) >> 30;
         s    = k + 2;
         return (s >= 0) ? (m << s) : (m >> (-s));
      endfunction

      function logic [31:0] standardize(logic signed [31:0] sample);
         longint x, a, b, c, d, r;
         x = longint'(sample);
         a = longint'(coef_a);
         b = longint'(coef_b);
         c = longint'(coef_c);
         case (kind)
            KIND_EXP: begin
               r = (a >>> 8) + scaled_product(b,
                      longint'(exp_q32(limit_arg(scaled_product(c, x, 16)))), 40);
               if (!benefit) r = longint'(top) - r;
            end
            KIND_QUAD:
               r = scaled_product(a, x * x, 40) + scaled_product(b, x, 24) + (c >>> 8);
            KIND_GAUSS: begin
               d = x * 256 - c;
               d = scaled_product(d, d, 24);
               r = scaled_product(a,
                      longint'(exp_q32(limit_arg(scaled_product(b, d, 24)))), 40);
               if (!benefit) r = longint'(top) - r;
            end
            default: r = longint'(bottom);
         endcase
         // With crossed bounds, values below the lower bound give it and all others the upper.
         if (r < longint'(bottom)) r = longint'(bottom);
         else if (r > longint'(top)) r = longint'(top);
         return r[31:0];
      endfunction

      function void note_sample(logic [31:0] sample);
         expected_y.push_back(standardize(sample));
      endfunction

      function void check_result(logic [31:0] y);
         logic [31:0] want;
         if (expected_y.size() == 0) begin
            $display("%0t: unexpected result word, standard_y actual %h", $time, y);
            failures++;
         end else begin
            want = expected_y.pop_front();
            if (want !== y) begin
               $display("%0t: standard_y expected %h actual %h", $time, want, y);
               failures++;
            end
         end
      endfunction

      function int pending();
         return expected_y.size();
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic [SAMPLE_W-1:0]    req_sample_x;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic [SAMPLE_W-1:0]    rsp_standard_y;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   curve_scoreboard sb = new();

   // Sender burst bookkeeping and the request for one long receiver hold-off.
   int burst_left = 0;
   bit hold_request = 1'b0;

   curve_value_standardizer dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_sample_x  (req_sample_x),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_standard_y(rsp_standard_y),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always begin
      clock = 1'b0; #6;
      clock = 1'b1; #6;
   end

   // Every accepted result word is checked against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_result(rsp_standard_y);
   end

   // The receiver switches among stall styles, keeping each for a random stretch. On request it
   // refuses words for a long stretch so that the pipeline fills and stops taking input.
   initial begin
      int style_left;
      int style;
      style_left = 0;
      style = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_ready <= 1'b0;
            hold_request = 1'b0;
            repeat (300) @(posedge clock);
         end else begin
            if (style_left == 0) begin
               style = $urandom_range(0, 3);
               style_left = $urandom_range(8, 80);
            end
            style_left--;
            case (style)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= 1'($urandom_range(0, 1));
               2: rsp_ready <= ($urandom_range(0, 3) == 0);
               default: rsp_ready <= ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   // Offers one sample word. Between bursts the sender goes quiet for a random gap;
   // a zero gap keeps valid high straight into the next burst.
   task automatic send_sample(input logic [31:0] x);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      req_valid    <= 1'b1;
      req_sample_x <= x;
      do @(posedge clock); while (!req_ready);
      sb.note_sample(x);
      burst_left--;
   endtask

   // Waits for every predicted word to come back, then lets the pipeline settle.
   task automatic drain_results();
      req_valid <= 1'b0;
      burst_left = 0;
      while (sb.pending() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Issues one register write and leaves valid high; the caller lowers it.
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      sb.set_reg(idx, data);
   endtask

   task automatic load_curve(input curve_kind_type kind, input bit benefit,
                             input logic [47:0] a, input logic [47:0] b,
                             input logic [47:0] c, input logic [31:0] top,
                             input logic [31:0] bottom);
      write_reg(CSR_CURVE_KIND, CSR_DATA_W'(kind));
      write_reg(CSR_BENEFIT_MODE, CSR_DATA_W'(benefit));
      write_reg(CSR_COEF_A, a);
      write_reg(CSR_COEF_B, b);
      write_reg(CSR_COEF_C, c);
      write_reg(CSR_DOMAIN_TOP, CSR_DATA_W'(top));
      write_reg(CSR_DOMAIN_BOTTOM, CSR_DATA_W'(bottom));
      csr_valid <= 1'b0;
   endtask

   // Mostly moderate values so the curves stay inside the domain, with full-range
   // words and the two extremes mixed in.
   function automatic logic [31:0] random_sample();
      case ($urandom_range(0, 5))
         0, 1:    return $urandom;
         2:       return 32'($urandom_range(0, 1 << 21)) - 32'(1 << 20);
         3:       return 32'($urandom_range(0, 1 << 19)) - 32'(1 << 18);
         4:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: return 32'($urandom_range(0, 1 << 17)) - 32'(1 << 16);
      endcase
   endfunction

   function automatic logic [47:0] random_coef();
      case ($urandom_range(0, 5))
         0:       return 48'({$urandom, $urandom});
         1:       return $urandom_range(0, 1) ? 48'h7FFF_FFFF_FFFF : 48'h8000_0000_0000;
         2:       return 48'($urandom_range(0, 1 << 21)) - 48'(1 << 20);
         default: return 48'($urandom_range(0, 1 << 28)) - 48'(1 << 27);
      endcase
   endfunction

   initial begin
      logic [31:0] edge_samples[12];
      logic [47:0] a, b, c;
      logic [31:0] top, bottom;
      curve_kind_type kind;
      int count;

      edge_samples = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0001_0000,
                       32'hFFFF_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h5555_5555,
                       32'hAAAA_AAAA, 32'h0014_0000, 32'hFFE8_0000, 32'h0000_8000};

      reset        <= 1'b1;
      req_valid    <= 1'b0;
      req_sample_x <= '0;
      csr_valid    <= 1'b0;
      csr_index    <= CSR_CURVE_KIND;
      csr_wdata    <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // The reset register values must already give a working curve.
      repeat (20) send_sample(random_sample());
      drain_results();

      // Edge samples on a unit exponential over the widest domain; the largest ones
      // push the exp argument into saturation at both ends.
      load_curve(KIND_EXP, 1'b1, 48'd0, 48'd1 << 24, 48'd1 << 24,
                 32'h7FFF_FFFF, 32'h8000_0000);
      foreach (edge_samples[i]) send_sample(edge_samples[i]);
      drain_results();

      // Random phases walk through all four kinds, both modes, crossed bounds and
      // extreme coefficients. One phase also holds the receiver off for a long time.
      for (int ph = 0; ph < 24; ph++) begin
         kind = curve_kind_type'(ph % 4);
         a = random_coef();
         b = random_coef();
         c = random_coef();
         if (ph == 5) begin
            a = 48'h7FFF_FFFF_FFFF; b = 48'h7FFF_FFFF_FFFF; c = 48'h7FFF_FFFF_FFFF;
         end else if (ph == 6) begin
            a = 48'h8000_0000_0000; b = 48'h8000_0000_0000; c = 48'h8000_0000_0000;
         end
         case (ph % 5)
            0: begin
               bottom = '0;
               top = 32'h0001_0000;
            end
            1: begin
               bottom = 32'($urandom_range(0, 1 << 23)) - 32'(1 << 22);
               top = bottom + 32'($urandom_range(0, 1 << 22));
            end
            2: begin
               // Crossed bounds: the lower bound lies above the upper one.
               top = 32'($urandom_range(0, 1 << 20));
               bottom = top + 32'($urandom_range(1, 1 << 20));
            end
            3: begin
               top = 32'h7FFF_FFFF;
               bottom = 32'h8000_0000;
            end
            default: begin
               top = $urandom;
               bottom = $urandom;
            end
         endcase
         // The write past the register list goes first, so the curve load that
         // follows keeps valid high without a second update in the same step.
         if (ph == 3) write_reg(CSR_UNUSED, CSR_DATA_W'({$urandom, $urandom}));
         load_curve(kind, 1'($urandom_range(0, 1)), a, b, c, top, bottom);
         if (ph == 10) hold_request = 1'b1;
         count = $urandom_range(40, 50);
         repeat (count) send_sample(random_sample());
         drain_results();
      end

      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #(12 * 400000);
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
`default_nettype wire

// File: curve_value_standardizer.f
hw/rtl/cvs_pkg.sv
hw/rtl/cvs_mul_sat.sv
hw/rtl/cvs_exp.sv
hw/rtl/curve_value_standardizer.sv
verif/curve_value_standardizer_tb.sv
